### rtl/sss_pkg.sv
// Shared types and constants for the separator stream splitter.
// Holds the input/result word structs, the config register codes and the step codes.
// No dependencies.
`timescale 1ns / 1ps

package sss_pkg;

  // Config port geometry
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;
  localparam int SEP_LEN_W  = 4;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_WORD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_LEN  = 1'b1;

  // Input word actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Result word kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_MARK = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] piece_byte;
    logic       run_last;
  } out_word_t;

  // One decision of the scan sequencer
  typedef enum logic [1:0] {
    STEP_STOP,
    STEP_BYTE,
    STEP_MARK
  } step_op_t;

  typedef struct packed {
    step_op_t op;
  } step_t;

endpackage

### rtl/sss_step.sv
// Decision unit of the splitter: compares the window head with the separator prefix.
// Depends on sss_pkg (step_t, step codes).
`timescale 1ns / 1ps

module sss_step #(
  parameter int SEP_MAX = 8,
  parameter int CNT_W   = 4
) (
  input  logic [SEP_MAX-1:0][7:0]       win,
  input  logic [CNT_W-1:0]              cnt,
  input  logic [CNT_W-1:0]              len,
  input  logic                          flush,
  input  logic [sss_pkg::CFG_DATA_W-1:0] sep_word,
  output sss_pkg::step_t                step
);

  logic [SEP_MAX-1:0][7:0] sep_bytes;
  logic [SEP_MAX-1:0]      eq;
  logic [SEP_MAX-1:0]      in_range;
  logic [CNT_W-1:0]        mlen;
  logic                    match;
  logic                    full;

  // Compare length: whole separator if enough bytes are held, else what is held
  assign full = (cnt >= len);
  assign mlen = full ? len : cnt;

  // Per-byte compare; separator bytes past the config word read as zero
  for (genvar i = 0; i < SEP_MAX; i++) begin : g_cmp
    if (i < 8) begin : g_word
      assign sep_bytes[i] = sep_word[8*i +: 8];
    end else begin : g_zero
      assign sep_bytes[i] = 8'h00;
    end
    assign eq[i]       = (win[i] == sep_bytes[i]);
    assign in_range[i] = (CNT_W'(i) < mlen);
  end

  assign match = &(eq | ~in_range);

  // Pick the next action of the scan
  always_comb begin
    if (flush) begin
      step.op = (cnt != '0) ? sss_pkg::STEP_BYTE : sss_pkg::STEP_MARK;
    end else if (cnt == '0) begin
      step.op = sss_pkg::STEP_STOP;
    end else if (full && match) begin
      step.op = sss_pkg::STEP_MARK;
    end else if (!full && match) begin
      step.op = sss_pkg::STEP_STOP;
    end else begin
      step.op = sss_pkg::STEP_BYTE;
    end
  end

endmodule

### rtl/split_stream_on_separator.sv
// Top level of the separator stream splitter: sequencer, window and output register.
// Depends on sss_pkg and sss_step.
`timescale 1ns / 1ps

// Usage:
//   in_*   : one word per source byte (action 0) or end of source (action 1).
//   out_*  : piece data bytes (kind 0) and piece-end markers (kind 1); run_last
//            flags the last word caused by one input word.
//   cfg_*  : index 0 writes the separator bytes (first byte in bits 7..0),
//            index 1 the separator length. Write only while in_ready is high
//            and no result is pending.
// Timing: an input word is taken in the idle state, then the shared compare unit
//   runs one decision per cycle while the output is not stalled, each producing at
//   most one result. A word that yields R results occupies the block for the accept,
//   R scan steps and a final step; in_ready is low meanwhile. Each result is held in
//   the pending register and moves to out_valid at the next step, the last at the final step.
// Reset: rst_n (synchronous) empties the window, drops any pending result,
//   and loads separator 0x00 with length 1.
// Stall: when out_ready is low and the output register holds a word, the scan
//   holds; the output register keeps its word until taken.
module split_stream_on_separator #(
  parameter int SEP_MAX = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sss_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sss_pkg::out_word_t             out_data,
  input  logic                           cfg_we,
  input  logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(SEP_MAX + 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                            state_r, state_nxt;
  logic [SEP_MAX-1:0][7:0]           win_r, win_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic                              flush_r, flush_nxt;
  logic                              pend_valid_r, pend_valid_nxt;
  logic                              pend_kind_r, pend_kind_nxt;
  logic [7:0]                        pend_byte_r, pend_byte_nxt;
  logic                              out_valid_r, out_valid_nxt;
  sss_pkg::out_word_t                out_data_r, out_data_nxt;
  logic [sss_pkg::CFG_DATA_W-1:0]    sep_word_r, sep_word_nxt;
  logic [sss_pkg::SEP_LEN_W-1:0]     sep_len_r, sep_len_nxt;

  logic [CNT_W-1:0]                  len;
  logic                              can_step;
  sss_pkg::step_t                    step;
  logic [SEP_MAX-1:0][7:0]           win_sh1;
  logic [SEP_MAX-1:0][7:0]           win_shl;

  // Clamp the configured length to 1..SEP_MAX
  always_comb begin
    if (sep_len_r == '0) begin
      len = CNT_W'(1);
    end else if (32'(sep_len_r) > SEP_MAX) begin
      len = CNT_W'(SEP_MAX);
    end else begin
      len = CNT_W'(sep_len_r);
    end
  end

  sss_step #(
    .SEP_MAX (SEP_MAX),
    .CNT_W   (CNT_W)
  ) u_step (
    .win      (win_r),
    .cnt      (cnt_r),
    .len      (len),
    .flush    (flush_r),
    .sep_word (sep_word_r),
    .step     (step)
  );

  // Window advanced by one byte and by a whole separator
  always_comb begin
    win_sh1 = win_r;
    win_shl = win_r;
    for (int i = 0; i < SEP_MAX - 1; i++) begin
      win_sh1[i] = win_r[i+1];
    end
    for (int i = 0; i < SEP_MAX; i++) begin
      for (int k = 1; k < SEP_MAX; k++) begin
        if ((len == CNT_W'(k)) && (i + k < SEP_MAX)) begin
          win_shl[i] = win_r[i+k];
        end
      end
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign can_step  = (state_r == ST_RUN) && (!out_valid_r || out_ready);

  // Sequencer and config next-state logic
  always_comb begin
    state_nxt      = state_r;
    win_nxt        = win_r;
    cnt_nxt        = cnt_r;
    flush_nxt      = flush_r;
    pend_valid_nxt = pend_valid_r;
    pend_kind_nxt  = pend_kind_r;
    pend_byte_nxt  = pend_byte_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    sep_word_nxt   = sep_word_r;
    sep_len_nxt    = sep_len_r;

    // Drop the output word once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Config writes
    if (cfg_we) begin
      case (cfg_index)
        sss_pkg::CFG_SEP_WORD: sep_word_nxt = cfg_wdata;
        sss_pkg::CFG_SEP_LEN:  sep_len_nxt  = cfg_wdata[sss_pkg::SEP_LEN_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        // Take a word: append a byte or arm the end flush
        if (in_valid) begin
          state_nxt = ST_RUN;
          if (in_data.action == sss_pkg::ACT_END) begin
            flush_nxt = 1'b1;
          end else begin
            for (int i = 0; i < SEP_MAX; i++) begin
              if (CNT_W'(i) == cnt_r) begin
                win_nxt[i] = in_data.data_byte;
              end
            end
            cnt_nxt = CNT_W'(cnt_r + 1'b1);
          end
        end
      end
      ST_RUN: begin
        if (can_step) begin
          case (step.op)
            sss_pkg::STEP_STOP: begin
              // Release the held result as the last of this word
              if (pend_valid_r) begin
                out_valid_nxt           = 1'b1;
                out_data_nxt.kind       = pend_kind_r;
                out_data_nxt.piece_byte = pend_byte_r;
                out_data_nxt.run_last   = 1'b1;
              end
              pend_valid_nxt = 1'b0;
              state_nxt      = ST_IDLE;
            end
            sss_pkg::STEP_BYTE, sss_pkg::STEP_MARK: begin
              // Push the held result, hold the new one
              if (pend_valid_r) begin
                out_valid_nxt           = 1'b1;
                out_data_nxt.kind       = pend_kind_r;
                out_data_nxt.piece_byte = pend_byte_r;
                out_data_nxt.run_last   = 1'b0;
              end
              pend_valid_nxt = 1'b1;
              if (step.op == sss_pkg::STEP_BYTE) begin
                pend_kind_nxt = sss_pkg::KIND_DATA;
                pend_byte_nxt = win_r[0];
                win_nxt       = win_sh1;
                cnt_nxt       = CNT_W'(cnt_r - 1'b1);
              end else begin
                pend_kind_nxt = sss_pkg::KIND_MARK;
                pend_byte_nxt = 8'h00;
                if (flush_r) begin
                  flush_nxt = 1'b0;
                end else begin
                  win_nxt = win_shl;
                  cnt_nxt = cnt_r - len;
                end
              end
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    win_r       <= win_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_byte_r <= pend_byte_nxt;
    out_data_r  <= out_data_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      flush_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      sep_word_r   <= '0;
      sep_len_r    <= sss_pkg::SEP_LEN_W'(1);
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      flush_r      <= flush_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      sep_word_r   <= sep_word_nxt;
      sep_len_r    <= sep_len_nxt;
    end
  end

`ifndef SYNTHESIS
  // Idle means nothing held back and the window short of a full scan buffer
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!pend_valid_r && !flush_r && (cnt_r < CNT_W'(SEP_MAX))))
    else $error("idle with pending result, flush or overfull window");

  // Window never exceeds the scan buffer
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SEP_MAX))
    else $error("window count out of range");

  // Finishing a word with a held result sends it flagged as last
  a_last_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && can_step && step.op == sss_pkg::STEP_STOP && pend_valid_r)
    |=> (out_valid_r && out_data_r.run_last))
    else $error("final result not flagged as last");

  // A flush step that finds the window empty closes the piece
  a_flush_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && can_step && flush_r && cnt_r == '0)
    |=> (pend_valid_r && pend_kind_r == sss_pkg::KIND_MARK && !flush_r))
    else $error("end flush did not close the piece");
`endif

endmodule

### tb/sv/tb_top.sv
// Testbench for split_stream_on_separator: directed and random byte streams, checked word by word
// against an in-bench predictor of the separator scan. Depends on sss_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int SEP_MAX       = 8;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES   = 20;
  localparam int ITEM_TARGET   = 430;
  localparam int CYCLE_LIMIT   = 1500000;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  sss_pkg::in_word_t              in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  sss_pkg::out_word_t             out_data;
  logic                           cfg_we = 1'b0;
  logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  split_stream_on_separator #(.SEP_MAX(SEP_MAX)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Splitter state mirrored by the predictor
  logic [63:0]        sep_word_q = 64'h0;
  logic [3:0]         sep_len_q = 4'd1;
  logic [7:0]         window_q [SEP_MAX];
  int unsigned        window_n = 0;

  sss_pkg::out_word_t pending_pieces [$];
  int unsigned        mismatch_count = 0;
  int unsigned        items_sent = 0;
  int unsigned        cycle_count = 0;
  bit                 quiet_mode = 1'b0;

  // Mostly short gaps, a few long ones; none at all in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned sep_len_eff();
    if (sep_len_q == 4'd0) return 1;
    if (sep_len_q > SEP_MAX) return SEP_MAX;
    return sep_len_q;
  endfunction

  function automatic logic [7:0] sep_byte_at(int unsigned i);
    if (i >= 8) return 8'h00;
    return sep_word_q[8*i +: 8];
  endfunction

  function automatic bit window_is_prefix(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (window_q[i] != sep_byte_at(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Release k bytes from the front of the window
  function automatic void drop_front(int unsigned k);
    for (int unsigned i = 0; i + k < window_n; i++) window_q[i] = window_q[i + k];
    window_n -= k;
  endfunction

  function automatic sss_pkg::out_word_t piece_word(logic kind, logic [7:0] b);
    sss_pkg::out_word_t w;
    w.kind       = kind;
    w.piece_byte = b;
    w.run_last   = 1'b0;
    return w;
  endfunction

  function automatic sss_pkg::in_word_t source_word(logic [7:0] b);
    sss_pkg::in_word_t w;
    w.action    = sss_pkg::ACT_BYTE;
    w.data_byte = b;
    return w;
  endfunction

  function automatic sss_pkg::in_word_t end_word();
    sss_pkg::in_word_t w;
    w.action    = sss_pkg::ACT_END;
    w.data_byte = 8'($urandom_range(0, 255));
    return w;
  endfunction

  // Work out the words that one accepted input word causes and queue them
  function automatic void predict_split(sss_pkg::in_word_t w);
    sss_pkg::out_word_t res [$];
    sss_pkg::out_word_t tail;
    int unsigned        len;
    len = sep_len_eff();
    if (w.action == sss_pkg::ACT_END) begin
      for (int unsigned i = 0; i < window_n; i++) begin
        res.push_back(piece_word(sss_pkg::KIND_DATA, window_q[i]));
      end
      res.push_back(piece_word(sss_pkg::KIND_MARK, 8'h00));
      window_n = 0;
    end else begin
      window_q[window_n] = w.data_byte;
      window_n++;
      while (window_n > 0) begin
        if (window_n >= len && window_is_prefix(len)) begin
          res.push_back(piece_word(sss_pkg::KIND_MARK, 8'h00));
          drop_front(len);
        end else if (window_n < len && window_is_prefix(window_n)) begin
          break;
        end else begin
          res.push_back(piece_word(sss_pkg::KIND_DATA, window_q[0]));
          drop_front(1);
        end
      end
    end
    if (res.size() > 0) begin
      tail = res[res.size() - 1];
      tail.run_last = 1'b1;
      res[res.size() - 1] = tail;
    end
    foreach (res[i]) pending_pieces.push_back(res[i]);
  endfunction

  function automatic void flag_mismatch(string what, sss_pkg::out_word_t want,
                                        sss_pkg::out_word_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch (%s) at cycle %0d: expected kind=%0d byte=%02h last=%0d,",
               what, cycle_count, want.kind, want.piece_byte, want.run_last,
               " got kind=%0d byte=%02h last=%0d",
               got.kind, got.piece_byte, got.run_last);
    end
  endfunction

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : check_results
    sss_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pieces.size() == 0) begin
        flag_mismatch("unexpected word", '0, out_data);
      end else begin
        want = pending_pieces.pop_front();
        if (out_data.kind !== want.kind || out_data.piece_byte !== want.piece_byte ||
            out_data.run_last !== want.run_last) begin
          flag_mismatch("field", want, out_data);
        end
      end
    end
  end

  // Stall the result side in random stretches
  initial begin : drive_out_ready
    int stall;
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Stop a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Offer one word, hold it until taken, then maybe idle
  task automatic send_word(input sss_pkg::in_word_t w);
    int gap;
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_split(w);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every expected word, then let a silent word finish
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_pieces.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both separator registers while the block is idle
  task automatic load_separator(input logic [63:0] word, input logic [3:0] len);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_index <= sss_pkg::CFG_SEP_WORD;
    cfg_wdata <= word;
    @(posedge clk);
    cfg_index <= sss_pkg::CFG_SEP_LEN;
    cfg_wdata <= {{(sss_pkg::CFG_DATA_W - sss_pkg::SEP_LEN_W){1'b0}}, len};
    @(posedge clk);
    cfg_we     <= 1'b0;
    sep_word_q = word;
    sep_len_q  = len;
  endtask

  task automatic test_empty_source();
    send_word(end_word());
  endtask

  // Reset separator is a single zero byte
  task automatic test_default_separator();
    send_word(source_word(8'h00));
    send_word(source_word(8'hFF));
    send_word(end_word());
  endtask

  task automatic test_length_zero();
    load_separator(64'h2C, 4'd0);
    send_word(source_word(8'h2C));
    send_word(source_word(8'h41));
    send_word(end_word());
  endtask

  // Length above the maximum clamps; a late mismatch releases the full window
  task automatic test_overlong_length();
    load_separator(64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    repeat (7) send_word(source_word(8'hFF));
    send_word(source_word(8'h00));
    send_word(end_word());
  endtask

  // Held bytes get scanned again against the new separator
  task automatic test_reconfig_midstream();
    load_separator(64'h63_62_61, 4'd3);
    send_word(source_word(8'h61));
    send_word(source_word(8'h62));
    load_separator(64'h62, 4'd1);
    send_word(source_word(8'h78));
    send_word(end_word());
  endtask

  // A failed match start backs up one byte
  task automatic test_backtrack();
    load_separator(64'h62_61_61, 4'd3);
    send_word(source_word(8'h61));
    send_word(source_word(8'h61));
    send_word(source_word(8'h61));
    send_word(source_word(8'h62));
    send_word(end_word());
  endtask

  task automatic test_random_streams();
    logic [63:0] word;
    logic [3:0]  len;
    logic [7:0]  b;
    int          r;
    int          style;
    int          phase_len;
    int unsigned eff;
    bit          broken;
    while (items_sent < ITEM_TARGET) begin
      // Pick a separator: extremes of the length now and then
      r = $urandom_range(0, 9);
      if (r == 0) len = 4'd0;
      else if (r == 1) len = 4'($urandom_range(9, 15));
      else if (r == 2) len = 4'd8;
      else len = 4'($urandom_range(1, 8));
      style = $urandom_range(0, 99);
      b = 8'($urandom_range(0, 255));
      for (int i = 0; i < 8; i++) begin
        if (style < 40) word[8*i +: 8] = 8'($urandom_range(0, 255));
        else if (style < 70) word[8*i +: 8] = $urandom_range(0, 1) ? 8'h62 : 8'h61;
        else if (style < 85) word[8*i +: 8] = b;
        else word[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      load_separator(word, len);
      eff = sep_len_eff();
      quiet_mode = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(8, 40);
      for (int k = 0; k < phase_len && items_sent < ITEM_TARGET; k++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_word(end_word());
        end else if (r < 30) begin
          // Whole separator, sometimes with its last byte corrupted
          broken = ($urandom_range(0, 3) == 0);
          for (int unsigned i = 0; i < eff; i++) begin
            b = sep_byte_at(i);
            if (broken && i == eff - 1) b = b ^ 8'($urandom_range(1, 255));
            send_word(source_word(b));
          end
        end else if (r < 85) begin
          send_word(source_word(sep_byte_at($urandom_range(0, eff - 1))));
        end else begin
          send_word(source_word(8'($urandom_range(0, 255))));
        end
        if ($urandom_range(0, 49) == 0) settle_block();
      end
      // Leave some streams open so the next separator rescans held bytes
      if ($urandom_range(0, 2) != 0) send_word(end_word());
    end
    quiet_mode = 1'b0;
  endtask

  initial begin : run_tests
    for (int i = 0; i < SEP_MAX; i++) window_q[i] = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_source();
    test_default_separator();
    test_length_zero();
    test_overlong_length();
    test_reconfig_midstream();
    test_backtrack();
    test_random_streams();
    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
